// ===== design/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define DFR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("dfr assertion failed");

// checked on every rising edge, reset included
`define DFR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("dfr assertion failed");

`endif

// ===== design/dfr_pkg.sv =====
package dfr_pkg;

  localparam int unsigned PRESSURE_BYTES = 460;
  localparam int unsigned ANGLE_VALUES   = 19;
  localparam int unsigned TAIL_VALUES    = 4;
  localparam int unsigned NUM_CHANNELS   = 19;

  localparam int unsigned ANGLE_OFS_I = 6 + PRESSURE_BYTES;
  localparam int unsigned SUM_OFS_I   = ANGLE_OFS_I + 2 * ANGLE_VALUES + 2 * TAIL_VALUES;
  localparam int unsigned FRAME_I     = SUM_OFS_I + 2;

  localparam int unsigned POS_W  = 10;
  localparam int unsigned ADDR_W = 10;
  localparam int unsigned IDX_W  = 5;

  localparam logic [POS_W-1:0] FRAME_BYTES  = POS_W'(FRAME_I);
  localparam logic [POS_W-1:0] LAST_POS     = POS_W'(FRAME_I - 1);
  localparam logic [POS_W-1:0] SUM_OFFSET   = POS_W'(SUM_OFS_I);
  localparam logic [POS_W-1:0] ANGLE_OFFSET = POS_W'(ANGLE_OFS_I);
  localparam logic [POS_W-1:0] ANGLE_END    = POS_W'(ANGLE_OFS_I + 2 * ANGLE_VALUES - 1);
  localparam logic [POS_W-1:0] POS_TYPE     = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LEN_HI   = POS_W'(4);
  localparam logic [POS_W-1:0] POS_DTYPE    = POS_W'(5);
  localparam logic [IDX_W-1:0] LAST_CHANNEL = IDX_W'(NUM_CHANNELS - 1);
  localparam logic [IDX_W-1:0] CHANNELS     = IDX_W'(NUM_CHANNELS);

  localparam logic [7:0] HDR_FIRST  = 8'hA5;
  localparam logic [7:0] HDR_SECOND = 8'h5A;
  localparam logic [7:0] FRAME_TYPE = 8'h01;
  localparam logic [7:0] DTYPE_A    = 8'h01;
  localparam logic [7:0] DTYPE_B    = 8'h70;

  localparam logic CFG_MIN = 1'b0;
  localparam logic CFG_MAX = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic signed [15:0] value;
    logic [IDX_W-1:0]   index;
    logic [7:0]         dtype;
    logic               last;
  } item_t;

  typedef struct packed {
    logic             busy;
    logic [POS_W-1:0] fill;
  } status_t;

endpackage

// ===== design/dfr_ram.sv =====
module dfr_ram #(
  parameter int unsigned AW = 10,
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/dfr_core.sv =====
module dfr_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_restart_i,
  input  logic signed [15:0]   lim_min_i,
  input  logic signed [15:0]   lim_max_i,
  output logic                 item_valid_o,
  input  logic                 item_ready_i,
  output dfr_pkg::item_t       item_o,
  output dfr_pkg::status_t     status_o
);

  dfr_pkg::state_e state_q, state_d;

  logic [dfr_pkg::ADDR_W-1:0] head_q;
  logic [dfr_pkg::POS_W-1:0]  fill_q, pos_q, rpos_q;
  logic                       rdv_q, ok_q, prev_a5_q;
  logic [15:0]                sum_q, len_q, learned_len_q;
  logic [7:0]                 lo_q, dt_q, learned_type_q;
  logic                       len_known_q, type_known_q;
  logic [dfr_pkg::IDX_W-1:0]  emit_idx_q;
  logic signed [15:0]         ang_q [dfr_pkg::NUM_CHANNELS];

  logic                       acc, issue, we;
  logic [dfr_pkg::ADDR_W-1:0] waddr, raddr;
  logic [7:0]                 b;
  logic [15:0]                word;
  logic [dfr_pkg::POS_W-1:0]  cnt_eff, fill_acc, ang_off;
  logic [dfr_pkg::IDX_W-1:0]  ang_idx;
  logic                       in_angles, ok_n, found, chk_done, scan_end, emit_go;

  dfr_ram #(.AW(dfr_pkg::ADDR_W), .DW(8)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_byte_i),
    .raddr_i (raddr),
    .rdata_o (b)
  );

  assign in_ready_o = (state_q == dfr_pkg::ST_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign cnt_eff    = in_restart_i ? '0 : fill_q;
  assign issue      = ((state_q == dfr_pkg::ST_CHECK) || (state_q == dfr_pkg::ST_SCAN)) &&
                      (pos_q < dfr_pkg::FRAME_BYTES);
  assign raddr      = head_q + dfr_pkg::ADDR_W'(pos_q);
  assign word       = {b, lo_q};
  assign ang_off    = rpos_q - dfr_pkg::ANGLE_OFFSET;
  assign ang_idx    = ang_off[dfr_pkg::IDX_W:1];
  assign in_angles  = (rpos_q >= dfr_pkg::ANGLE_OFFSET) && (rpos_q <= dfr_pkg::ANGLE_END);
  assign found      = prev_a5_q && (b == dfr_pkg::HDR_SECOND);
  assign chk_done   = (state_q == dfr_pkg::ST_CHECK) && rdv_q && (rpos_q == dfr_pkg::LAST_POS);
  assign scan_end   = (state_q == dfr_pkg::ST_SCAN) && rdv_q &&
                      (found || (rpos_q == dfr_pkg::LAST_POS));
  assign emit_go    = (state_q == dfr_pkg::ST_EMIT) && item_ready_i;
  assign we         = acc;

  // byte placement on append; a lone A5 stays at the head
  always_comb begin
    waddr    = head_q + dfr_pkg::ADDR_W'(cnt_eff);
    fill_acc = cnt_eff + 1'b1;
    if (cnt_eff == '0) begin
      fill_acc = (in_byte_i == dfr_pkg::HDR_FIRST) ? dfr_pkg::POS_W'(1) : '0;
    end else if (cnt_eff == dfr_pkg::POS_W'(1)) begin
      if (in_byte_i == dfr_pkg::HDR_SECOND) begin
        fill_acc = dfr_pkg::POS_W'(2);
      end else if (in_byte_i == dfr_pkg::HDR_FIRST) begin
        waddr    = head_q;
        fill_acc = dfr_pkg::POS_W'(1);
      end else begin
        fill_acc = '0;
      end
    end
  end

  // shared compare unit: one stored byte per cycle
  always_comb begin
    ok_n = ok_q;
    if (rpos_q == dfr_pkg::POS_TYPE) begin
      if (b != dfr_pkg::FRAME_TYPE) ok_n = 1'b0;
    end else if (rpos_q == dfr_pkg::POS_LEN_HI) begin
      if (word == 16'd0 || (len_known_q && word != learned_len_q)) ok_n = 1'b0;
    end else if (rpos_q == dfr_pkg::POS_DTYPE) begin
      if ((b != dfr_pkg::DTYPE_A && b != dfr_pkg::DTYPE_B) ||
          (type_known_q && b != learned_type_q)) ok_n = 1'b0;
    end else if (in_angles && ang_off[0] && ang_idx < dfr_pkg::CHANNELS) begin
      if ($signed(word) < lim_min_i || $signed(word) > lim_max_i) ok_n = 1'b0;
    end else if (rpos_q == dfr_pkg::LAST_POS) begin
      if (word != sum_q) ok_n = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      dfr_pkg::ST_IDLE: begin
        if (acc && cnt_eff >= dfr_pkg::POS_W'(2) && fill_acc == dfr_pkg::FRAME_BYTES) begin
          state_d = dfr_pkg::ST_CHECK;
        end
      end
      dfr_pkg::ST_CHECK: begin
        if (chk_done) state_d = ok_n ? dfr_pkg::ST_EMIT : dfr_pkg::ST_SCAN;
      end
      dfr_pkg::ST_SCAN: begin
        if (scan_end) state_d = dfr_pkg::ST_IDLE;
      end
      dfr_pkg::ST_EMIT: begin
        if (emit_go && emit_idx_q == dfr_pkg::LAST_CHANNEL) state_d = dfr_pkg::ST_IDLE;
      end
      default: state_d = dfr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dfr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q         <= '0;
      fill_q         <= '0;
      pos_q          <= '0;
      rdv_q          <= 1'b0;
      len_known_q    <= 1'b0;
      type_known_q   <= 1'b0;
      learned_len_q  <= '0;
      learned_type_q <= '0;
      emit_idx_q     <= '0;
    end else begin
      rdv_q <= issue;
      if (issue) pos_q <= pos_q + 1'b1;
      if (acc) begin
        fill_q <= fill_acc;
        if (in_restart_i) begin
          len_known_q    <= 1'b0;
          type_known_q   <= 1'b0;
          learned_len_q  <= '0;
          learned_type_q <= '0;
        end
        if (state_d == dfr_pkg::ST_CHECK) pos_q <= '0;
      end
      if (chk_done) begin
        if (ok_n) begin
          emit_idx_q <= '0;
          fill_q     <= '0;
          if (!len_known_q) begin
            len_known_q   <= 1'b1;
            learned_len_q <= len_q;
          end
          if (!type_known_q) begin
            type_known_q   <= 1'b1;
            learned_type_q <= dt_q;
          end
        end else begin
          pos_q <= dfr_pkg::POS_W'(1);
        end
      end
      if (scan_end) begin
        if (found) begin
          head_q <= head_q + dfr_pkg::ADDR_W'(rpos_q - 1'b1);
          fill_q <= dfr_pkg::FRAME_BYTES + 1'b1 - rpos_q;
        end else if (b == dfr_pkg::HDR_FIRST) begin
          head_q <= head_q + dfr_pkg::ADDR_W'(dfr_pkg::LAST_POS);
          fill_q <= dfr_pkg::POS_W'(1);
        end else begin
          fill_q <= '0;
        end
      end
      if (emit_go) emit_idx_q <= emit_idx_q + 1'b1;
    end
  end

  // datapath registers of the shared unit
  always_ff @(posedge clk_i) begin
    rpos_q <= pos_q;
    if (acc) begin
      ok_q      <= 1'b1;
      sum_q     <= '0;
      prev_a5_q <= 1'b0;
    end
    if (chk_done) prev_a5_q <= 1'b0;
    if (rdv_q) begin
      lo_q <= b;
      if (state_q == dfr_pkg::ST_CHECK) begin
        ok_q <= ok_n;
        if (rpos_q < dfr_pkg::SUM_OFFSET) sum_q <= sum_q + 16'(b);
        if (rpos_q == dfr_pkg::POS_LEN_HI) len_q <= word;
        if (rpos_q == dfr_pkg::POS_DTYPE) dt_q <= b;
        if (in_angles && ang_off[0] && ang_idx < dfr_pkg::CHANNELS) ang_q[ang_idx] <= word;
      end else if (state_q == dfr_pkg::ST_SCAN) begin
        prev_a5_q <= (b == dfr_pkg::HDR_FIRST);
      end
    end
  end

  assign item_valid_o   = (state_q == dfr_pkg::ST_EMIT);
  assign item_o.value   = ang_q[emit_idx_q];
  assign item_o.index   = emit_idx_q;
  assign item_o.dtype   = dt_q;
  assign item_o.last    = (emit_idx_q == dfr_pkg::LAST_CHANNEL);
  assign status_o.busy  = (state_q != dfr_pkg::ST_IDLE);
  assign status_o.fill  = fill_q;

endmodule

// ===== design/sync_header_frame_deframer_top.sv =====
// sync-header frame deframer
// input stream: one received byte per transfer on s_axis_tdata, s_axis_tuser
// set restarts the stream (store and learned length and type cleared first).
// output stream: one transfer per channel of a good frame, channel order,
// m_axis_tlast on the final channel. config writes via cfg_we_i/cfg_idx_i:
// index 0 sets the low angle limit, index 1 the high limit (signed).
// a byte that does not complete a 514-byte frame leaves s_axis_tready high.
// a completed frame is read back through one ram port, one byte a cycle,
// for checksum and field checks. a bad frame is then rescanned for the
// next header; a good frame sends its 19 channels, one per cycle while
// the receiver takes them. s_axis_tready is low during all of that;
// mean cost per byte stays small.
// a stalled receiver holds the output register and the emission sequence.
// after reset the store is empty, nothing is learned, limits are full range.
`include "assert_macros.svh"

module sync_header_frame_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] channel_value, [20:16] channel_index,
                                      // [28:21] frame_data_type, zero above
  output logic        m_axis_tlast,   // last_channel
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic signed [15:0] lim_min_q, lim_max_q;
  logic               item_valid, item_ready, out_valid_q;
  dfr_pkg::item_t     item, out_q;
  dfr_pkg::status_t   core_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_min_q <= 16'sh8000;
      lim_max_q <= 16'sh7FFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dfr_pkg::CFG_MIN: lim_min_q <= cfg_data_i;
        dfr_pkg::CFG_MAX: lim_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dfr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_restart_i (s_axis_tuser),
    .lim_min_i    (lim_min_q),
    .lim_max_i    (lim_max_q),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item),
    .status_o     (core_status)
  );

  // output register decouples the core from a stalled receiver
  assign item_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (item_ready) begin
      out_valid_q <= item_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_ready && item_valid) out_q <= item;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.dtype, out_q.index, out_q.value};
  assign m_axis_tlast  = out_q.last;

  `DFR_ASSERT(a_fill_bound, core_status.fill <= dfr_pkg::FRAME_BYTES)
  `DFR_ASSERT(a_idle_not_full, s_axis_tready |-> core_status.fill < dfr_pkg::FRAME_BYTES)
  `DFR_ASSERT(a_busy_not_ready, core_status.busy != s_axis_tready)
  `DFR_ASSERT(a_last_index,
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[20:16] == dfr_pkg::LAST_CHANNEL)))

endmodule
